### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl, clocked on i_clk and held off during i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SSA_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssa assertion failed");

// next-cycle implication
`define SSA_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssa assertion failed");

`endif

### hw/rtl/ssa_pkg.sv
`default_nettype none

package ssa_pkg;

    // ring depth default
    localparam int AVG_DEPTH_DEF = 6;

    localparam int DATA_W = 16;

    // register reset values
    localparam logic [15:0] MINUTE_TICKS_RST  = 16'd60;
    localparam logic [7:0]  SLOW_INTERVAL_RST = 8'd10;
    localparam logic [15:0] FAST_INTERVAL_RST = 16'd3;
    localparam logic [15:0] FAST_WINDOW_RST   = 16'd120;

    // register indexes (word address)
    localparam logic [1:0] REG_MINUTE_TICKS  = 2'd0;
    localparam logic [1:0] REG_SLOW_INTERVAL = 2'd1;
    localparam logic [1:0] REG_FAST_INTERVAL = 2'd2;
    localparam logic [1:0] REG_FAST_WINDOW   = 2'd3;

    // op codes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_TRST  = 3'd2;
    localparam logic [2:0] OP_KEY   = 3'd3;
    localparam logic [2:0] OP_INIT  = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_READY   = 2'd1,
        PH_COLLECT = 2'd2,
        PH_FINISH  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [15:0] minute_ticks;
        logic [7:0]  slow_interval;
        logic [15:0] fast_interval;
        logic [15:0] fast_window;
    } t_cfg;

    // control outcome of one word
    typedef struct packed {
        t_phase phase;
        logic   start;
        logic   taken;
        logic   refresh;
        logic   fast;
    } t_step;

endpackage

`default_nettype wire

### hw/rtl/ssa_in_if.sv
`default_nettype none

interface ssa_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [15:0] sample_value;

    modport source (output valid, output op, output sample_value, input ready);
    modport sink   (input valid, input op, input sample_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/ssa_out_if.sv
`default_nettype none

interface ssa_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         phase;
    logic               start_conversion;
    logic               sample_taken;
    logic signed [15:0] current_temp;
    logic signed [15:0] average_temp;
    logic               refresh_done;
    logic               fast_active;

    modport source (
        output valid, output phase, output start_conversion, output sample_taken,
        output current_temp, output average_temp, output refresh_done,
        output fast_active, input ready
    );
    modport sink (
        input valid, input phase, input start_conversion, input sample_taken,
        input current_temp, input average_temp, input refresh_done,
        input fast_active, output ready
    );
endinterface

`default_nettype wire

### hw/rtl/ssa_cfg.sv
`default_nettype none

module ssa_cfg
    import ssa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready,
    output      t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.minute_ticks  <= MINUTE_TICKS_RST;
            r_cfg.slow_interval <= SLOW_INTERVAL_RST;
            r_cfg.fast_interval <= FAST_INTERVAL_RST;
            r_cfg.fast_window   <= FAST_WINDOW_RST;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_MINUTE_TICKS:  r_cfg.minute_ticks  <= pwdata[15:0];
                REG_SLOW_INTERVAL: r_cfg.slow_interval <= pwdata[7:0];
                REG_FAST_INTERVAL: r_cfg.fast_interval <= pwdata[15:0];
                REG_FAST_WINDOW:   r_cfg.fast_window   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MINUTE_TICKS:  prdata = {16'd0, r_cfg.minute_ticks};
            REG_SLOW_INTERVAL: prdata = {24'd0, r_cfg.slow_interval};
            REG_FAST_INTERVAL: prdata = {16'd0, r_cfg.fast_interval};
            REG_FAST_WINDOW:   prdata = {16'd0, r_cfg.fast_window};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/ssa_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module ssa_ctrl
    import ssa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_adv,
    input  wire logic [2:0] i_op,
    input  wire t_cfg       i_cfg,
    output      t_step      o_step
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_mc, n_mc;
    logic [7:0]  r_sc, n_sc;
    logic [15:0] r_fwc, n_fwc;
    logic [15:0] r_fic, n_fic;
    logic        r_fast, n_fast;

    logic [15:0] w_mc_inc, w_fwc_inc, w_fic_inc;
    logic [7:0]  w_sc_inc;
    logic        w_start, w_taken, w_refresh;

    // saturating increments
    assign w_mc_inc  = (r_mc  == 16'hFFFF) ? r_mc  : r_mc  + 16'd1;
    assign w_fwc_inc = (r_fwc == 16'hFFFF) ? r_fwc : r_fwc + 16'd1;
    assign w_fic_inc = (r_fic == 16'hFFFF) ? r_fic : r_fic + 16'd1;
    assign w_sc_inc  = (r_sc  == 8'hFF)    ? r_sc  : r_sc  + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_mc    <= '0;
            r_sc    <= '0;
            r_fwc   <= '0;
            r_fic   <= '0;
            r_fast  <= 1'b0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_mc    <= n_mc;
            r_sc    <= n_sc;
            r_fwc   <= n_fwc;
            r_fic   <= n_fic;
            r_fast  <= n_fast;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_mc      = r_mc;
        n_sc      = r_sc;
        n_fwc     = r_fwc;
        n_fic     = r_fic;
        n_fast    = r_fast;
        w_start   = 1'b0;
        w_taken   = 1'b0;
        w_refresh = 1'b0;
        unique case (i_op)
            OP_TICK: begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (r_fast) begin
                            if (w_fwc_inc <= i_cfg.fast_window) begin
                                n_fwc = w_fwc_inc;
                                if (w_fic_inc >= i_cfg.fast_interval) begin
                                    n_phase = PH_READY;
                                    n_fic   = '0;
                                end else begin
                                    n_fic = w_fic_inc;
                                end
                            end else begin
                                n_fast = 1'b0;
                                n_fwc  = '0;
                            end
                        end else if (w_mc_inc >= i_cfg.minute_ticks) begin
                            n_mc = '0;
                            if (w_sc_inc >= i_cfg.slow_interval) begin
                                n_phase = PH_READY;
                                n_sc    = '0;
                            end else begin
                                n_phase = PH_FINISH;
                                n_sc    = w_sc_inc;
                            end
                        end else begin
                            n_mc = w_mc_inc;
                        end
                    end
                    PH_READY: begin
                        w_start = 1'b1;
                        n_phase = PH_COLLECT;
                    end
                    PH_COLLECT: begin
                        w_taken = 1'b1;
                        n_phase = PH_FINISH;
                    end
                    PH_FINISH: begin
                        w_refresh = 1'b1;
                        n_phase   = PH_IDLE;
                    end
                    default: ;
                endcase
            end
            OP_START: n_phase = PH_READY;
            OP_TRST: begin
                n_mc  = '0;
                n_sc  = '0;
                n_fwc = '0;
                n_fic = i_cfg.fast_interval - 16'd1;
            end
            OP_KEY:  n_fast = 1'b1;
            OP_INIT: begin
                n_mc = i_cfg.minute_ticks - 16'd1;
                n_sc = i_cfg.slow_interval - 8'd1;
            end
            default: ;
        endcase
    end

    assign o_step.phase   = n_phase;
    assign o_step.start   = w_start;
    assign o_step.taken   = w_taken;
    assign o_step.refresh = w_refresh;
    assign o_step.fast    = n_fast;

    // window count only runs while fast mode is on
    `SSA_AST_IMP(a_window_idle, !r_fast, r_fwc == 16'd0)

endmodule

`default_nettype wire

### hw/rtl/ssa_avg.sv
`default_nettype none

module ssa_avg
    import ssa_pkg::*;
#(
    parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_take,
    input  wire logic signed [15:0] i_sample,
    output      logic signed [15:0] o_temp,
    output      logic signed [15:0] o_avg
);

    localparam int LOG_D  = $clog2(AVG_DEPTH);
    localparam int PTR_W  = LOG_D;
    localparam int SUM_W  = DATA_W + LOG_D;
    localparam int SH     = SUM_W + LOG_D;
    localparam int REC_W  = SH - LOG_D + 1;
    localparam int PROD_W = SUM_W + REC_W;
    // ceil(2^SH / depth): exact floor division for every magnitude below 2^SUM_W
    localparam logic [REC_W-1:0] RECIP =
        REC_W'(((64'd1 << SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(AVG_DEPTH - 1);

    logic signed [15:0]      r_ring [AVG_DEPTH];
    logic [PTR_W-1:0]        r_ptr, n_ptr;
    logic                    r_full, n_full;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic signed [15:0]      r_temp, r_avg, n_avg;

    logic signed [15:0]      w_old;
    logic                    w_last, w_neg;
    logic [SUM_W-1:0]        w_mag;
    logic [PROD_W-1:0]       w_prod;
    logic [15:0]             w_q;

    // entries are read only after a full pass, so the ring needs no clearing
    assign w_old  = r_full ? r_ring[r_ptr] : 16'sd0;
    assign w_last = (r_ptr == PTR_LAST);
    assign n_ptr  = w_last ? '0 : r_ptr + PTR_W'(1);
    assign n_full = r_full | w_last;
    assign n_sum  = r_sum - {{(SUM_W-DATA_W){w_old[15]}}, w_old}
                          + {{(SUM_W-DATA_W){i_sample[15]}}, i_sample};

    // mean truncated toward zero: divide the magnitude, restore the sign
    assign w_neg  = n_sum[SUM_W-1];
    assign w_mag  = w_neg ? SUM_W'(-n_sum) : SUM_W'(n_sum);
    assign w_prod = PROD_W'(w_mag) * PROD_W'(RECIP);
    assign w_q    = w_prod[SH +: 16];
    assign n_avg  = n_full ? (w_neg ? -$signed(w_q) : $signed(w_q)) : i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_full <= 1'b0;
            r_sum  <= '0;
            r_temp <= '0;
            r_avg  <= '0;
        end else if (i_take) begin
            r_ptr  <= n_ptr;
            r_full <= n_full;
            r_sum  <= n_sum;
            r_temp <= i_sample;
            r_avg  <= n_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_ring[r_ptr] <= i_sample;
        end
    end

    assign o_temp = i_take ? i_sample : r_temp;
    assign o_avg  = i_take ? n_avg : r_avg;

endmodule

`default_nettype wire

### hw/rtl/sensor_sample_scheduler_avg_core.sv
// flow: a word accepted into the input register is loaded into the result register once that
// is empty or being drained, and its result word can then be taken from there
// throughput: one word per cycle while the result side keeps taking words, set by the single
// input register and result register stage, with all work for a word in the logic between them
// reset: synchronous active-low i_rst_n clears phase, counters, ring state and valids;
// registers return to 60, 10, 3 and 120
`default_nettype none
`include "assert_macros.svh"

module sensor_sample_scheduler_avg_core
    import ssa_pkg::*;
#(
    parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ssa_in_if.sink           i_in,
    ssa_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    typedef struct packed {
        t_step              step;
        logic signed [15:0] temp;
        logic signed [15:0] avg;
    } t_res;

    t_cfg               w_cfg;
    t_step              w_step;
    logic signed [15:0] w_temp, w_avg;

    // input register
    logic               r_in_vld;
    logic [2:0]         r_op;
    logic signed [15:0] r_sample;

    // result register
    logic               r_out_vld;
    t_res               r_res;

    logic               w_adv;

    // the held word moves on when the result register is empty or being drained
    assign w_adv      = r_in_vld & (~r_out_vld | o_out.ready);
    assign i_in.ready = ~r_in_vld | w_adv;

    // config registers on the apb side
    ssa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // phase sequencer and tick scheduler
    ssa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_op    (r_op),
        .i_cfg   (w_cfg),
        .o_step  (w_step)
    );

    // sample ring with running sum and mean
    ssa_avg #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_avg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_adv & w_step.taken),
        .i_sample (r_sample),
        .o_temp   (w_temp),
        .o_avg    (w_avg)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_op     <= i_in.op;
            r_sample <= i_in.sample_value;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res.step <= w_step;
            r_res.temp <= w_temp;
            r_res.avg  <= w_avg;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.phase            = r_res.step.phase;
    assign o_out.start_conversion = r_res.step.start;
    assign o_out.sample_taken     = r_res.step.taken;
    assign o_out.current_temp     = r_res.temp;
    assign o_out.average_temp     = r_res.avg;
    assign o_out.refresh_done     = r_res.step.refresh;
    assign o_out.fast_active      = r_res.step.fast;

    // pulses only come with the phase that follows them
    `SSA_AST_IMP(a_start_phase, r_out_vld && r_res.step.start, r_res.step.phase == PH_COLLECT)
    `SSA_AST_IMP(a_taken_phase, r_out_vld && r_res.step.taken, r_res.step.phase == PH_FINISH)
    `SSA_AST_IMP(a_refresh_phase, r_out_vld && r_res.step.refresh, r_res.step.phase == PH_IDLE)
    // a word leaving the input stage always lands in the result register
    `SSA_AST_NXT(a_adv_loads, w_adv, r_out_vld)

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ssa_pkg::*;

    localparam int RING_DEPTH        = AVG_DEPTH_DEF;
    localparam int WORDS_PER_SETTING = 120;
    localparam int STALL_LIMIT       = 2000;
    localparam int DRAIN_CYCLES      = 8;

    // op codes the block has no use for
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // one result word as the sequencer should report it
    typedef struct packed {
        t_phase             phase;
        logic               start_conv;
        logic               taken;
        logic signed [15:0] cur_temp;
        logic signed [15:0] avg_temp;
        logic               refresh;
        logic               fast;
    } t_seq_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ssa_in_if  in_if ();
    ssa_out_if out_if ();

    sensor_sample_scheduler_avg_core #(
        .AVG_DEPTH(RING_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // sequencer state as the testbench tracks it
    // ------------------------------------------------------------------
    t_cfg               cfg_shadow;
    t_phase             st_phase;
    logic [15:0]        st_minute_cnt;
    logic [7:0]         st_slow_cnt;
    logic [15:0]        st_win_cnt;
    logic [15:0]        st_intv_cnt;
    logic               st_fast;
    logic signed [15:0] st_ring [RING_DEPTH];
    int                 st_ring_ptr;
    logic               st_ring_full;
    int                 st_sum;
    logic signed [15:0] st_last_temp;
    logic signed [15:0] st_last_avg;

    // expected result words, oldest first
    t_seq_out pending_outputs[$];

    int error_count    = 0;
    int words_sent     = 0;
    int words_checked  = 0;
    int settings_used  = 1;
    int stored_count   = 0;
    int conv_count     = 0;
    int refresh_count  = 0;
    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int hold_cycles    = 0;
    int idle_cycles    = 0;

    function automatic void clear_sequencer();
        cfg_shadow.minute_ticks  = MINUTE_TICKS_RST;
        cfg_shadow.slow_interval = SLOW_INTERVAL_RST;
        cfg_shadow.fast_interval = FAST_INTERVAL_RST;
        cfg_shadow.fast_window   = FAST_WINDOW_RST;
        st_phase      = PH_IDLE;
        st_minute_cnt = '0;
        st_slow_cnt   = '0;
        st_win_cnt    = '0;
        st_intv_cnt   = '0;
        st_fast       = 1'b0;
        foreach (st_ring[i]) st_ring[i] = '0;
        st_ring_ptr   = 0;
        st_ring_full  = 1'b0;
        st_sum        = 0;
        st_last_temp  = '0;
        st_last_avg   = '0;
    endfunction

    // idle-phase scheduling: fast window first, else minute / slow counting
    function automatic void run_schedule();
        if (st_fast) begin
            if (st_win_cnt != 16'hFFFF) st_win_cnt = st_win_cnt + 16'd1;
            if (st_win_cnt <= cfg_shadow.fast_window) begin
                if (st_intv_cnt != 16'hFFFF) st_intv_cnt = st_intv_cnt + 16'd1;
                if (st_intv_cnt >= cfg_shadow.fast_interval) begin
                    st_phase    = PH_READY;
                    st_intv_cnt = '0;
                end
            end else begin
                // window over, back to slow mode
                st_fast    = 1'b0;
                st_win_cnt = '0;
            end
        end else begin
            if (st_minute_cnt != 16'hFFFF) st_minute_cnt = st_minute_cnt + 16'd1;
            if (st_minute_cnt >= cfg_shadow.minute_ticks) begin
                st_phase      = PH_FINISH;
                st_minute_cnt = '0;
                if (st_slow_cnt != 8'hFF) st_slow_cnt = st_slow_cnt + 8'd1;
                if (st_slow_cnt >= cfg_shadow.slow_interval) begin
                    st_phase    = PH_READY;
                    st_slow_cnt = '0;
                end
            end
        end
    endfunction

    // ring write with running sum, mean truncated toward zero once full
    function automatic void store_reading(logic signed [15:0] s);
        st_sum = st_sum - int'(st_ring[st_ring_ptr]) + int'(s);
        st_ring[st_ring_ptr] = s;
        st_ring_ptr++;
        if (st_ring_ptr >= RING_DEPTH) begin
            st_ring_full = 1'b1;
            st_ring_ptr  = 0;
        end
        st_last_temp = s;
        st_last_avg  = st_ring_full ? 16'(st_sum / RING_DEPTH) : s;
    endfunction

    function automatic t_seq_out advance_sequencer(logic [2:0] op, logic signed [15:0] s);
        t_seq_out r;
        r = '0;
        case (op)
            OP_TICK: begin
                case (st_phase)
                    PH_IDLE:  run_schedule();
                    PH_READY: begin
                        r.start_conv = 1'b1;
                        st_phase     = PH_COLLECT;
                    end
                    PH_COLLECT: begin
                        store_reading(s);
                        r.taken  = 1'b1;
                        st_phase = PH_FINISH;
                    end
                    default: begin
                        r.refresh = 1'b1;
                        st_phase  = PH_IDLE;
                    end
                endcase
            end
            OP_START: st_phase = PH_READY;
            OP_TRST: begin
                st_minute_cnt = '0;
                st_slow_cnt   = '0;
                st_win_cnt    = '0;
                st_intv_cnt   = cfg_shadow.fast_interval - 16'd1;
            end
            OP_KEY:  st_fast = 1'b1;
            OP_INIT: begin
                st_minute_cnt = cfg_shadow.minute_ticks - 16'd1;
                st_slow_cnt   = cfg_shadow.slow_interval - 8'd1;
            end
            default: ;
        endcase
        r.phase    = st_phase;
        r.cur_temp = st_last_temp;
        r.avg_temp = st_last_avg;
        r.fast     = st_fast;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // result side: random ready, with an optional long hold-off
    // ------------------------------------------------------------------
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                hold_cycles--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // compare every accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        t_seq_out want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_outputs.size() == 0) begin
                $error("result word with nothing pending");
                error_count++;
            end else begin
                want = pending_outputs.pop_front();
                check_field("phase", want.phase, out_if.phase);
                check_field("start_conversion", want.start_conv, out_if.start_conversion);
                check_field("sample_taken", want.taken, out_if.sample_taken);
                check_field("current_temp", want.cur_temp, out_if.current_temp);
                check_field("average_temp", want.avg_temp, out_if.average_temp);
                check_field("refresh_done", want.refresh, out_if.refresh_done);
                check_field("fast_active", want.fast, out_if.fast_active);
                words_checked++;
                stored_count  += want.taken;
                conv_count    += want.start_conv;
                refresh_count += want.refresh;
            end
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("no word moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // offer one word, predict its result at acceptance, maybe idle afterwards
    task automatic send_word(logic [2:0] op, logic signed [15:0] s);
        in_if.valid        <= 1'b1;
        in_if.op           <= op;
        in_if.sample_value <= s;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        pending_outputs.push_back(advance_sequencer(op, s));
        words_sent++;
        if ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    // stop offering and wait for every expected result word
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_outputs.size() != 0);
    endtask

    // apb write then read back, shadow copy follows the write edge
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        logic [31:0] held;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_MINUTE_TICKS: begin
                cfg_shadow.minute_ticks = val[15:0];
                held = {16'd0, val[15:0]};
            end
            REG_SLOW_INTERVAL: begin
                cfg_shadow.slow_interval = val[7:0];
                held = {24'd0, val[7:0]};
            end
            REG_FAST_INTERVAL: begin
                cfg_shadow.fast_interval = val[15:0];
                held = {16'd0, val[15:0]};
            end
            default: begin
                cfg_shadow.fast_window = val[15:0];
                held = {16'd0, val[15:0]};
            end
        endcase
        // read back through a fresh setup / access pair
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        check_field("prdata", held, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_setting(logic [15:0] mt, logic [7:0] si, logic [15:0] fi,
                                 logic [15:0] fw);
        write_reg(REG_MINUTE_TICKS, {16'd0, mt});
        write_reg(REG_SLOW_INTERVAL, {24'd0, si});
        write_reg(REG_FAST_INTERVAL, {16'd0, fi});
        write_reg(REG_FAST_WINDOW, {16'd0, fw});
        settings_used++;
    endtask

    // short periods mostly so the scheduler fires often, now and then the range ends
    task automatic program_random_setting();
        logic [15:0] mt;
        logic [7:0]  si;
        logic [15:0] fi;
        logic [15:0] fw;
        if ($urandom_range(5) == 0) begin
            mt = $urandom_range(1) ? 16'hFFFF : 16'd1;
            si = $urandom_range(1) ? 8'hFF : 8'd1;
            fi = $urandom_range(1) ? 16'hFFFF : 16'd1;
            fw = $urandom_range(1) ? 16'd65534 : 16'd0;
        end else begin
            mt = 16'($urandom_range(5, 1));
            si = 8'($urandom_range(3, 1));
            fi = 16'($urandom_range(4, 1));
            fw = 16'($urandom_range(24, 0));
        end
        write_setting(mt, si, fi, fw);
    endtask

    // mostly ticks so sample sequences run through, plus requests and noise
    function automatic logic [2:0] pick_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return OP_TICK;
        if (r < 77) return OP_START;
        if (r < 83) return OP_KEY;
        if (r < 87) return OP_TRST;
        if (r < 91) return OP_INIT;
        return 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    endfunction

    function automatic logic signed [15:0] pick_reading();
        case ($urandom_range(11))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every op, field extremes, one slow-mode and one fast-mode sample
    task automatic test_directed();
        // spare op codes leave everything alone
        for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) send_word(3'(c), 16'sh7FFF);
        send_word(OP_TICK, 16'sh7FFF);
        send_word(OP_TICK, 16'sh8000);
        // forced sample of the positive extreme
        send_word(OP_START, 16'sh0000);
        send_word(OP_TICK, 16'sh8000);
        send_word(OP_TICK, 16'sh7FFF);
        send_word(OP_TICK, 16'sh0000);
        // and of the negative extreme
        send_word(OP_START, 16'sh7FFF);
        send_word(OP_TICK, 16'sh7FFF);
        send_word(OP_TICK, 16'sh8000);
        send_word(OP_TICK, 16'sh7FFF);
        // init preloads both counters, next tick ends minute and slow period
        send_word(OP_INIT, 16'sh0000);
        send_word(OP_TICK, 16'sh1234);
        send_word(OP_TICK, 16'sh0000);
        send_word(OP_TICK, 16'shFFFF);
        send_word(OP_TICK, 16'sh0000);
        // key request then timer reset: first fast tick asks for a sample
        send_word(OP_KEY, 16'shFFFF);
        send_word(OP_TRST, 16'sh8000);
        send_word(OP_TICK, 16'sh0000);
        send_word(OP_TICK, 16'sh0000);
        send_word(OP_TICK, 16'sh5A5A);
        send_word(OP_TICK, 16'sh0000);
    endtask

    // all-zero registers (wrap and saturation), then the other registers at their top and the fast window one below it
    task automatic test_register_extremes();
        wait_drain();
        write_setting(16'd0, 8'd0, 16'd0, 16'd0);
        send_word(OP_TRST, pick_reading());
        send_word(OP_KEY, pick_reading());
        repeat (3) send_word(OP_TICK, pick_reading());
        // counters preload to all ones, where the increment saturates
        send_word(OP_INIT, pick_reading());
        repeat (6) send_word(OP_TICK, pick_reading());
        send_word(OP_KEY, pick_reading());
        repeat (4) send_word(OP_TICK, pick_reading());
        wait_drain();
        write_setting(16'hFFFF, 8'hFF, 16'hFFFF, 16'd65534);
        send_word(OP_INIT, pick_reading());
        repeat (4) send_word(OP_TICK, pick_reading());
        send_word(OP_KEY, pick_reading());
        send_word(OP_TRST, pick_reading());
        repeat (4) send_word(OP_TICK, pick_reading());
    endtask

    // receiver holds off while words keep coming, then the sender waits it out
    task automatic test_backpressure();
        int keep_src;
        keep_src = src_idle_pct;
        wait_drain();
        src_idle_pct = 0;
        hold_cycles  = 100;
        repeat (40) send_word(pick_op(), pick_reading());
        wait_drain();
        repeat (20) send_word(pick_op(), pick_reading());
        wait_drain();
        src_idle_pct = keep_src;
    endtask

    task automatic test_random_traffic(int settings, int src_pct, int sink_pct);
        int          effective;
        logic [2:0]  op;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (settings) begin
            wait_drain();
            program_random_setting();
            effective = 0;
            while (effective < WORDS_PER_SETTING) begin
                op = pick_op();
                send_word(op, pick_reading());
                // spare codes are ignored by the block, they do not count
                if (op <= OP_INIT) effective++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_if.valid        = 1'b0;
        in_if.op           = OP_TICK;
        in_if.sample_value = '0;
        src_idle_pct       = 27;
        sink_idle_pct      = 78;
        clear_sequencer();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random_traffic(4, 27, 78);
        test_random_traffic(4, 78, 27);
        test_random_traffic(4, 0, 0);

        // let anything stray come out before judging
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_outputs.size() != 0) begin
            $error("%0d result words never arrived", pending_outputs.size());
            error_count++;
        end

        $display("sent %0d words under %0d register settings, checked %0d results",
                 words_sent, settings_used, words_checked);
        $display("seen %0d conversions, %0d stored samples, %0d display refreshes",
                 conv_count, stored_count, refresh_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
